// ===== hdl/ste_pkg.sv =====
// Shared types, register indexes and the quarter-wave sine entry function.
package ste_pkg;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned AMP_W = 15;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned INC_W = 32;
	localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd1;

	// pi/2 in unsigned Q2.62
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef enum logic [1:0] {
		REG_PHASE_INC = 2'd0,
		REG_AMPLITUDE = 2'd1,
		REG_SAMPLE_COUNT = 2'd2
	} reg_idx_t;

	// Control that travels with a beat through the pipeline.
	typedef struct packed {
		logic valid;
		logic neg;
		logic last;
	} ctl_t;

	// Entry k of a quarter-wave table with 2^abits steps per quarter:
	// round-half-up of 32767 * sin(pi/2 * k / 2^abits), Q2.62 Taylor series.
	function automatic logic [AMP_W-1:0] sine_entry(int unsigned k, int unsigned abits);
		logic [127:0] p;
		logic [63:0] angle;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [65:0] v;
		logic sub;
		int unsigned n;
		p = 128'(HALF_PI_Q62) * 128'(k);
		angle = 64'(p >> abits);
		p = 128'(angle) * 128'(angle);
		x2 = p[125:62];
		term = angle;
		sum = angle;
		sub = 1'b1;
		for (n = 3; n <= 41; n = n + 2) begin
			p = 128'(term) * 128'(x2);
			term = p[125:62] / 64'((n - 1) * n);
			if (sub)
				sum = sum - term;
			else
				sum = sum + term;
			sub = !sub;
		end
		p = 128'(sum) * 128'(32767) + (128'(1) << 61);
		v = p[127:62];
		if (v > 66'd32767)
			v = 66'd32767;
		return v[AMP_W-1:0];
	endfunction

endpackage

// ===== hdl/sine_tone_generator_top.sv =====
// Direct digital synthesis sine tone source, top level.
// Stages: the phase add, ROM read and multiply each own a registered stage, in that order.
// Throughput: one sample per cycle while the output is not stalled.
// The output register has a skid slot; input stalls only while both of them hold a beat.
// Reset clears phase, run index and pipeline valids; registers return to their defaults.
module sine_tone_generator_top #(
	parameter int unsigned PHASE_BITS = 32,
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [ste_pkg::CFG_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic restart,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [ste_pkg::SAMPLE_W-1:0] sample,
	output logic last
);

	logic [ste_pkg::INC_W-1:0] phase_inc_q;
	logic [ste_pkg::AMP_W-1:0] amplitude_q;
	logic [ste_pkg::COUNT_W-1:0] count_q;
	logic en;
	logic [TABLE_ADDR_BITS:0] addr_s1;
	ste_pkg::ctl_t ctl_s1;
	ste_pkg::ctl_t ctl_s2;
	logic [ste_pkg::AMP_W-1:0] mag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= '0;
			amplitude_q <= ste_pkg::AMP_RESET;
			count_q <= ste_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ste_pkg::REG_PHASE_INC: phase_inc_q <= cfg_wdata[ste_pkg::INC_W-1:0];
				ste_pkg::REG_AMPLITUDE: amplitude_q <= cfg_wdata[ste_pkg::AMP_W-1:0];
				ste_pkg::REG_SAMPLE_COUNT: count_q <= cfg_wdata[ste_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = !en;

	ste_phase #(
		.PHASE_BITS(PHASE_BITS),
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS)
	) u_phase (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.restart(restart),
		.phase_inc(PHASE_BITS'(phase_inc_q)),
		.sample_count(count_q),
		.addr_s1(addr_s1),
		.ctl_s1(ctl_s1)
	);

	ste_sine_rom #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS)
	) u_rom (
		.clk(clk),
		.en(en),
		.addr(addr_s1),
		.data_s2(mag_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	ste_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s2(ctl_s2),
		.mag_s2(mag_s2),
		.amplitude(amplitude_q),
		.out_stall(out_stall),
		.en(en),
		.out_valid(out_valid),
		.sample(sample),
		.last(last)
	);

endmodule

// ===== hdl/ste_phase.sv =====
// Phase accumulator, run counter and quadrant folding into a table address.
module ste_phase #(
	parameter int unsigned PHASE_BITS = 32,
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic restart,
	input  logic [PHASE_BITS-1:0] phase_inc,
	input  logic [ste_pkg::COUNT_W-1:0] sample_count,
	output logic [TABLE_ADDR_BITS:0] addr_s1,
	output ste_pkg::ctl_t ctl_s1
);

	localparam int unsigned TOP_W = TABLE_ADDR_BITS + 2;
	localparam logic [TABLE_ADDR_BITS:0] QUARTER_LEN = (TABLE_ADDR_BITS+1)'(1) << TABLE_ADDR_BITS;

	logic [PHASE_BITS-1:0] phase_q;
	logic [ste_pkg::COUNT_W-1:0] index_q;
	logic [PHASE_BITS-1:0] cur_phase;
	logic [ste_pkg::COUNT_W-1:0] cur_index;
	logic [ste_pkg::COUNT_W-1:0] count;
	logic [TOP_W-1:0] top;
	logic [TABLE_ADDR_BITS-1:0] k;
	logic [TABLE_ADDR_BITS:0] addr;
	logic is_last;
	logic accept;

	assign accept = in_valid && en;
	assign cur_phase = restart ? '0 : phase_q;
	assign cur_index = restart ? '0 : index_q;
	// a zero run length behaves as one
	assign count = (sample_count == '0) ? ste_pkg::COUNT_W'(1) : sample_count;
	assign is_last = ({1'b0, cur_index} + 33'd1) >= {1'b0, count};

	assign top = cur_phase[PHASE_BITS-1 -: TOP_W];
	assign k = top[TABLE_ADDR_BITS-1:0];
	// mirror the index in odd quadrants
	assign addr = top[TABLE_ADDR_BITS] ? (QUARTER_LEN - {1'b0, k}) : {1'b0, k};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			index_q <= '0;
		end else if (accept) begin
			if (is_last) begin
				phase_q <= '0;
				index_q <= '0;
			end else begin
				phase_q <= cur_phase + phase_inc;
				index_q <= cur_index + ste_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_s1 <= '0;
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			if (accept) begin
				addr_s1 <= addr;
				ctl_s1.neg <= top[TABLE_ADDR_BITS+1];
				ctl_s1.last <= is_last;
			end
		end
	end

endmodule

// ===== hdl/ste_sine_rom.sv =====
// Quarter-wave sine ROM with registered read.
module ste_sine_rom #(
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  logic clk,
	input  logic en,
	input  logic [TABLE_ADDR_BITS:0] addr,
	output logic [ste_pkg::AMP_W-1:0] data_s2
);

	localparam int unsigned DEPTH = (1 << TABLE_ADDR_BITS) + 1;

	logic [ste_pkg::AMP_W-1:0] rom [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		localparam logic [ste_pkg::AMP_W-1:0] ENTRY = ste_pkg::sine_entry(i, TABLE_ADDR_BITS);
		assign rom[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s2 <= rom[addr];
	end

endmodule

// ===== hdl/ste_out_stage.sv =====
// Amplitude scaling, sign and the output register with its skid buffer.
module ste_out_stage (
	input  logic clk,
	input  logic arst_n,
	input  ste_pkg::ctl_t ctl_s2,
	input  logic [ste_pkg::AMP_W-1:0] mag_s2,
	input  logic [ste_pkg::AMP_W-1:0] amplitude,
	input  logic out_stall,
	output logic en,
	output logic out_valid,
	output logic signed [ste_pkg::SAMPLE_W-1:0] sample,
	output logic last
);

	logic [2*ste_pkg::AMP_W-1:0] prod;
	logic [ste_pkg::AMP_W-1:0] scaled;
	logic [ste_pkg::SAMPLE_W-1:0] sample_c;
	logic take_in;
	logic take_out;
	logic out_valid_q;
	logic skid_valid_q;
	logic [ste_pkg::SAMPLE_W-1:0] out_sample_q;
	logic [ste_pkg::SAMPLE_W-1:0] skid_sample_q;
	logic out_last_q;
	logic skid_last_q;

	assign prod = (2*ste_pkg::AMP_W)'(mag_s2) * (2*ste_pkg::AMP_W)'(amplitude);
	assign scaled = prod[2*ste_pkg::AMP_W-1 -: ste_pkg::AMP_W];
	assign sample_c = ctl_s2.neg ? (ste_pkg::SAMPLE_W'(0) - {1'b0, scaled}) : {1'b0, scaled};

	// the pipeline holds while the skid slot is full
	assign en = !skid_valid_q;
	assign take_in = ctl_s2.valid && !skid_valid_q;
	assign take_out = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take_out) begin
			out_valid_q <= skid_valid_q || take_in;
			skid_valid_q <= 1'b0;
		end else if (take_in) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take_out) begin
			if (skid_valid_q) begin
				out_sample_q <= skid_sample_q;
				out_last_q <= skid_last_q;
			end else if (take_in) begin
				out_sample_q <= sample_c;
				out_last_q <= ctl_s2.last;
			end
		end else if (take_in) begin
			skid_sample_q <= sample_c;
			skid_last_q <= ctl_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign sample = out_sample_q;
	assign last = out_last_q;

endmodule

// ===== hdl/ste_checker.sv =====
// Port-level checks for the sine tone generator, bound to the top level.
module ste_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [ste_pkg::SAMPLE_W-1:0] sample,
	input logic last
);

	// the most negative code never appears
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample != 16'sh8000))
		else $error("sample outside symmetric range");

	// input stalls only when a result is waiting at the output
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output beat pending");

	// a held beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last))
		else $error("stalled output beat changed");

	// after an idle output, the input is free again
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> !in_stall)
		else $error("input still stalled after output drained");

endmodule

bind sine_tone_generator_top ste_checker u_chk (.*);

// ===== bench/tone_monitor.sv =====
// Port monitor for the sine tone generator: predicts each sample and compares.
module tone_monitor #(
	parameter int unsigned PHASE_BITS = 32,
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [ste_pkg::CFG_W-1:0] cfg_wdata,
	input  logic in_valid,
	input  logic in_stall,
	input  logic restart,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [ste_pkg::SAMPLE_W-1:0] sample,
	input  logic last,
	output int errors,
	output int pending,
	output int checked,
	output int lasts
);

	localparam int unsigned QUARTER = 1 << TABLE_ADDR_BITS;
	localparam int unsigned TOP_W = TABLE_ADDR_BITS + 2;
	localparam real HALF_PI = 1.5707963267948966;

	typedef struct packed {
		logic [ste_pkg::SAMPLE_W-1:0] value;
		logic last;
	} tone_t;

	logic [ste_pkg::AMP_W-1:0] quarter_sine [0:QUARTER];

	logic [ste_pkg::INC_W-1:0] inc_reg;
	logic [ste_pkg::AMP_W-1:0] amp_reg;
	logic [ste_pkg::COUNT_W-1:0] count_reg;
	logic [PHASE_BITS-1:0] phase_acc;
	logic [31:0] run_idx;

	tone_t tone_q[$];
	tone_t want;
	int fail_count;
	int checked_count;
	int last_count;

	// Round-half-up of full scale times sin over one quarter wave.
	initial begin : build_quarter
		real r;
		for (int k = 0; k <= QUARTER; k++) begin
			r = $floor(32767.0 * $sin(HALF_PI * k / QUARTER) + 0.5);
			if (r > 32767.0)
				r = 32767.0;
			quarter_sine[k] = ste_pkg::AMP_W'($rtoi(r));
		end
	end

	function automatic tone_t next_tone(input logic rst);
		logic [TOP_W-1:0] top;
		logic [1:0] quad;
		logic [TABLE_ADDR_BITS:0] addr;
		logic [31:0] mag;
		logic [32:0] span;
		tone_t t;
		if (rst) begin
			phase_acc = '0;
			run_idx = '0;
		end
		top = phase_acc[PHASE_BITS-1 -: TOP_W];
		quad = top[TOP_W-1 -: 2];
		// mirror the index in odd quadrants
		if (quad[0])
			addr = (TABLE_ADDR_BITS+1)'(QUARTER) - {1'b0, top[TABLE_ADDR_BITS-1:0]};
		else
			addr = {1'b0, top[TABLE_ADDR_BITS-1:0]};
		mag = (32'(quarter_sine[addr]) * 32'(amp_reg)) >> 15;
		t.value = quad[1] ? ste_pkg::SAMPLE_W'(32'd0 - mag) : ste_pkg::SAMPLE_W'(mag);
		// a zero run length behaves as one
		span = (count_reg == '0) ? 33'd1 : {1'b0, count_reg};
		t.last = ({1'b0, run_idx} + 33'd1) >= span;
		if (t.last) begin
			phase_acc = '0;
			run_idx = '0;
		end else begin
			phase_acc = phase_acc + PHASE_BITS'(inc_reg);
			run_idx = run_idx + 32'd1;
		end
		return t;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 20)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_reg = '0;
			amp_reg = ste_pkg::AMP_RESET;
			count_reg = ste_pkg::COUNT_RESET;
			phase_acc = '0;
			run_idx = '0;
			tone_q.delete();
			fail_count = 0;
			checked_count = 0;
			last_count = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
			lasts <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tone_q.size() == 0) begin
					report_mismatch($sformatf("sample %0d last %0b with nothing pending",
						sample, last));
				end else begin
					want = tone_q.pop_front();
					if (sample !== want.value)
						report_mismatch($sformatf("sample %0d, predicted %0d",
							sample, $signed(want.value)));
					if (last !== want.last)
						report_mismatch($sformatf("last %0b, predicted %0b (sample %0d)",
							last, want.last, $signed(want.value)));
					checked_count++;
					if (want.last)
						last_count++;
				end
			end
			if (in_valid && !in_stall)
				tone_q.push_back(next_tone(restart));
			// register writes land after this edge's beat
			if (cfg_we) begin
				case (ste_pkg::reg_idx_t'(cfg_idx))
					ste_pkg::REG_PHASE_INC: inc_reg = cfg_wdata[ste_pkg::INC_W-1:0];
					ste_pkg::REG_AMPLITUDE: amp_reg = cfg_wdata[ste_pkg::AMP_W-1:0];
					ste_pkg::REG_SAMPLE_COUNT: count_reg = cfg_wdata[ste_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			errors <= fail_count;
			pending <= tone_q.size();
			checked <= checked_count;
			lasts <= last_count;
		end
	end

endmodule

// ===== bench/tb_sine_tone_generator_top.sv =====
// Testbench top for the sine tone generator: stimulus, flow control and verdict.
module tb_sine_tone_generator_top;

	localparam int TOTAL_BEATS = 1550;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [ste_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ste_pkg::SAMPLE_W-1:0] sample;
	logic last;

	int errors;
	int pending;
	int checked;
	int lasts;

	int beats_sent = 0;
	int restarts = 0;
	int phase_no = 0;
	int hold_req = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	sine_tone_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.last(last)
	);

	tone_monitor tone_mon (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.last(last),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.lasts(lasts)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 10));
	endfunction

	task automatic write_reg(input ste_pkg::reg_idx_t idx,
			input logic [ste_pkg::CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one beat after a random gap and hold it until taken.
	task automatic offer_beat(input logic rst);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		if (rst)
			restarts++;
	endtask

	// Drop valid and wait until every predicted sample has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic pick_settings();
		logic [ste_pkg::CFG_W-1:0] inc;
		logic [ste_pkg::CFG_W-1:0] amp;
		logic [ste_pkg::CFG_W-1:0] span;
		case ($urandom_range(0, 5))
			0: inc = '0;
			1: inc = 32'hFFFF_FFFF;
			2: inc = 32'd1 << $urandom_range(20, 31);
			3: inc = $urandom_range(1, 32'h0100_0000);
			default: inc = $urandom;
		endcase
		case ($urandom_range(0, 3))
			0: amp = $urandom & 32'hFFFF_8000;
			1: amp = $urandom | 32'h0000_7FFF;
			default: amp = $urandom;
		endcase
		case ($urandom_range(0, 6))
			0: span = '0;
			1: span = 32'd1;
			2: span = 32'hFFFF_FFFF;
			3: span = $urandom;
			default: span = $urandom_range(2, 40);
		endcase
		write_reg(ste_pkg::REG_PHASE_INC, inc);
		write_reg(ste_pkg::REG_AMPLITUDE, amp);
		write_reg(ste_pkg::REG_SAMPLE_COUNT, span);
	endtask

	// Sink side: random stall before each beat, or a long hold when asked.
	initial begin : sink
		int wait_cycles;
		wait (arst_n);
		forever begin
			wait_cycles = (hold_req > 0) ? hold_req : draw_gap(recv_calm);
			hold_req = 0;
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: zero step, single-sample runs
		offer_beat(1'b0);
		offer_beat(1'b1);
		drain();

		// zero run length, upper amplitude bits ignored
		write_reg(ste_pkg::REG_SAMPLE_COUNT, 32'd0);
		write_reg(ste_pkg::REG_PHASE_INC, 32'h4000_0000);
		write_reg(ste_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
		offer_beat(1'b0);
		offer_beat(1'b0);
		drain();

		// quarter-cycle step hits every quadrant edge, restart mid-run
		write_reg(ste_pkg::REG_SAMPLE_COUNT, 32'd8);
		for (int i = 0; i < 8; i++)
			offer_beat(i == 5);
		drain();

		// shorten the run below the current index
		write_reg(ste_pkg::REG_SAMPLE_COUNT, 32'd16);
		write_reg(ste_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
		repeat (5) offer_beat(1'b0);
		drain();
		write_reg(ste_pkg::REG_SAMPLE_COUNT, 32'd3);
		offer_beat(1'b0);
		drain();

		// zero amplitude with junk above the field
		write_reg(ste_pkg::REG_AMPLITUDE, 32'h0000_8000);
		write_reg(ste_pkg::REG_PHASE_INC, 32'h1234_5678);
		offer_beat(1'b0);
		offer_beat(1'b1);
		drain();

		while (beats_sent < TOTAL_BEATS) begin : random_phase
			int n;
			pick_settings();
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			// hold the sink long enough to back the pipeline up into the input
			if (phase_no == 2) begin
				send_calm = 1'b1;
				hold_req = 80;
			end
			n = $urandom_range(40, 140);
			if (n > TOTAL_BEATS - beats_sent)
				n = TOTAL_BEATS - beats_sent;
			repeat (n) offer_beat($urandom_range(0, 19) == 0);
			drain();
			phase_no++;
		end

		$display("Sent %0d beats (%0d with restart) over %0d random register settings.",
			beats_sent, restarts, phase_no);
		$display("Compared %0d samples, %0d of them closing a run.", checked, lasts);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ste_pkg.sv
hdl/ste_phase.sv
hdl/ste_sine_rom.sv
hdl/ste_out_stage.sv
hdl/sine_tone_generator_top.sv
hdl/ste_checker.sv
bench/tone_monitor.sv
bench/tb_sine_tone_generator_top.sv
